// File: rtl/sst_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and character helpers of the source tokenizer
package sst_pkg;

  localparam int OFFSET_BITS    = 24;
  localparam int LINE_BITS      = 20;
  localparam int COLUMN_BITS    = 16;
  localparam int KEYWORD_CHARS  = 8;
  localparam int KW_BITS        = 8 * KEYWORD_CHARS;
  localparam int KEYWORD_COUNT  = 30;
  localparam int BATCH_RECS     = 4;
  localparam int REC_IDX_BITS   = $clog2(BATCH_RECS);
  localparam int BATCH_CNT_BITS = $clog2(BATCH_RECS + 1);
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
  localparam int OUT_TDATA_BITS = 144;

  localparam logic [3:0] IDLEN_MAX = 4'd15;

  // record types
  localparam logic [1:0] REC_TOKEN = 2'd0;
  localparam logic [1:0] REC_BYTE  = 2'd1;
  localparam logic [1:0] REC_DIAG  = 2'd2;

  // diagnostic codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_UNEXPECTED = 3'd1;
  localparam logic [2:0] ERR_OPEN_CMT   = 3'd2;
  localparam logic [2:0] ERR_BAD_ESC    = 3'd3;
  localparam logic [2:0] ERR_NL_IN_STR  = 3'd4;
  localparam logic [2:0] ERR_OPEN_STR   = 3'd5;

  // token kinds
  localparam logic [6:0] KIND_IDENT   = 7'd30;
  localparam logic [6:0] KIND_EOF     = 7'd31;
  localparam logic [6:0] KIND_LBRACE  = 7'd32;
  localparam logic [6:0] KIND_RBRACE  = 7'd33;
  localparam logic [6:0] KIND_LPAREN  = 7'd34;
  localparam logic [6:0] KIND_RPAREN  = 7'd35;
  localparam logic [6:0] KIND_LBRACK  = 7'd36;
  localparam logic [6:0] KIND_RBRACK  = 7'd37;
  localparam logic [6:0] KIND_COMMA   = 7'd38;
  localparam logic [6:0] KIND_DOT     = 7'd39;
  localparam logic [6:0] KIND_DCOLON  = 7'd40;
  localparam logic [6:0] KIND_COLON   = 7'd41;
  localparam logic [6:0] KIND_SEMI    = 7'd42;
  localparam logic [6:0] KIND_AT      = 7'd43;
  localparam logic [6:0] KIND_QUEST   = 7'd44;
  localparam logic [6:0] KIND_PLUS    = 7'd45;
  localparam logic [6:0] KIND_ARROW   = 7'd46;
  localparam logic [6:0] KIND_MINUS   = 7'd47;
  localparam logic [6:0] KIND_STAR    = 7'd48;
  localparam logic [6:0] KIND_SLASH   = 7'd49;
  localparam logic [6:0] KIND_PERCENT = 7'd50;
  localparam logic [6:0] KIND_EQEQ    = 7'd51;
  localparam logic [6:0] KIND_ASSIGN  = 7'd52;
  localparam logic [6:0] KIND_NE      = 7'd53;
  localparam logic [6:0] KIND_BANG    = 7'd54;
  localparam logic [6:0] KIND_LE      = 7'd55;
  localparam logic [6:0] KIND_LT      = 7'd56;
  localparam logic [6:0] KIND_GE      = 7'd57;
  localparam logic [6:0] KIND_GT      = 7'd58;
  localparam logic [6:0] KIND_ANDAND  = 7'd59;
  localparam logic [6:0] KIND_AMP     = 7'd60;
  localparam logic [6:0] KIND_OROR    = 7'd61;
  localparam logic [6:0] KIND_PIPE    = 7'd62;
  localparam logic [6:0] KIND_INVALID = 7'd63;
  localparam logic [6:0] KIND_FLOAT   = 7'd64;
  localparam logic [6:0] KIND_INT     = 7'd65;
  localparam logic [6:0] KIND_STRING  = 7'd66;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // keywords, first character in the highest used byte (shift-in order)
  localparam logic [KW_BITS-1:0] KW_WORDS [KEYWORD_COUNT] = '{
    "true", "false", "null", "module", "use", "script", "fn", "return",
    "if", "else", "while", "for", "in", "let", "var", "const", "struct",
    "enum", "class", "signal", "on", "async", "await", "emit", "match",
    "break", "continue", "public", "private", "static"
  };

  typedef struct packed {
    logic [OFFSET_BITS-1:0] off;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
  } pos_t;

  localparam pos_t POS_START = '{off: '0, line: LINE_BITS'(1), col: COLUMN_BITS'(1)};

  typedef struct packed {
    logic [1:0] rtype;
    logic [6:0] kind;
    logic [2:0] err;
    logic [7:0] sbyte;
    pos_t       bpos;
    pos_t       epos;
  } rec_t;

  typedef struct packed {
    logic [BATCH_CNT_BITS-1:0]   cnt;
    rec_t [BATCH_RECS-1:0]       recs;
  } batch_t;

  typedef struct packed {
    logic       hit;
    logic       two;
    logic [6:0] kind;
  } punct_t;

  typedef struct packed {
    logic       bad;
    logic [7:0] val;
  } esc_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return (c == "_") || is_alpha(c) || is_digit(c);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) ||
           (c == CH_CR) || (c == CH_LF);
  endfunction

  // position after one byte, each counter saturating
  function automatic pos_t pos_adv(input pos_t p, input logic [7:0] b);
    pos_t q;
    q = p;
    if (p.off != '1) q.off = p.off + 1'b1;
    if (b == CH_LF) begin
      if (p.line != '1) q.line = p.line + 1'b1;
      q.col = COLUMN_BITS'(1);
    end else if (p.col != '1) begin
      q.col = p.col + 1'b1;
    end
    return q;
  endfunction

  function automatic logic [6:0] ident_kind(input logic [KW_BITS-1:0] kw,
                                            input logic [3:0] len);
    logic [6:0] k;
    k = KIND_IDENT;
    if (len <= 4'(KEYWORD_CHARS)) begin
      for (int i = 0; i < KEYWORD_COUNT; i++) begin
        if (kw == KW_WORDS[i]) k = 7'(i);
      end
    end
    return k;
  endfunction

  function automatic punct_t punct_find(input logic [7:0] c0, input logic [7:0] c1,
                                        input logic c1_ok);
    punct_t r;
    r.hit  = 1'b1;
    r.two  = 1'b0;
    r.kind = KIND_INVALID;
    case (c0)
      "{": r.kind = KIND_LBRACE;
      "}": r.kind = KIND_RBRACE;
      "(": r.kind = KIND_LPAREN;
      ")": r.kind = KIND_RPAREN;
      "[": r.kind = KIND_LBRACK;
      "]": r.kind = KIND_RBRACK;
      ",": r.kind = KIND_COMMA;
      ".": r.kind = KIND_DOT;
      ";": r.kind = KIND_SEMI;
      "@": r.kind = KIND_AT;
      "?": r.kind = KIND_QUEST;
      "+": r.kind = KIND_PLUS;
      "*": r.kind = KIND_STAR;
      "/": r.kind = KIND_SLASH;
      "%": r.kind = KIND_PERCENT;
      ":": begin
        r.two  = c1_ok && (c1 == ":");
        r.kind = r.two ? KIND_DCOLON : KIND_COLON;
      end
      "-": begin
        r.two  = c1_ok && (c1 == ">");
        r.kind = r.two ? KIND_ARROW : KIND_MINUS;
      end
      "=": begin
        r.two  = c1_ok && (c1 == "=");
        r.kind = r.two ? KIND_EQEQ : KIND_ASSIGN;
      end
      "!": begin
        r.two  = c1_ok && (c1 == "=");
        r.kind = r.two ? KIND_NE : KIND_BANG;
      end
      "<": begin
        r.two  = c1_ok && (c1 == "=");
        r.kind = r.two ? KIND_LE : KIND_LT;
      end
      ">": begin
        r.two  = c1_ok && (c1 == "=");
        r.kind = r.two ? KIND_GE : KIND_GT;
      end
      "&": begin
        r.two  = c1_ok && (c1 == "&");
        r.kind = r.two ? KIND_ANDAND : KIND_AMP;
      end
      "|": begin
        r.two  = c1_ok && (c1 == "|");
        r.kind = r.two ? KIND_OROR : KIND_PIPE;
      end
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic esc_t esc_decode(input logic [7:0] c);
    esc_t e;
    e.bad = 1'b0;
    case (c)
      "n":  e.val = CH_LF;
      "r":  e.val = CH_CR;
      "t":  e.val = CH_TAB;
      "0":  e.val = 8'h00;
      "\\": e.val = "\\";
      "\"": e.val = "\"";
      default: begin
        e.bad = 1'b1;
        e.val = c;
      end
    endcase
    return e;
  endfunction

  function automatic rec_t mk_rec(input logic [1:0] rtype, input logic [6:0] kind,
                                  input logic [2:0] err, input logic [7:0] sbyte,
                                  input pos_t bpos, input pos_t epos);
    rec_t r;
    r.rtype = rtype;
    r.kind  = kind;
    r.err   = err;
    r.sbyte = sbyte;
    r.bpos  = bpos;
    r.epos  = epos;
    return r;
  endfunction

endpackage

// File: rtl/sst_scan.sv
`timescale 1ns / 1ps
// scanner state and the one-pass decision logic for one item
module sst_scan (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_fire,
  input  logic [7:0]      item_byte,
  input  logic            item_eos,
  output sst_pkg::batch_t batch,
  output logic            batch_push
);

  localparam int SLOTS = 7;

  typedef enum logic [8:0] {
    MODE_IDLE    = 9'b000000001,
    MODE_LINE    = 9'b000000010,
    MODE_BLOCK   = 9'b000000100,
    MODE_IDENT   = 9'b000001000,
    MODE_INT     = 9'b000010000,
    MODE_FRAC    = 9'b000100000,
    MODE_EXPSIGN = 9'b001000000,
    MODE_EXPDIG  = 9'b010000000,
    MODE_STR     = 9'b100000000
  } mode_t;

  mode_t                        mode_r, mode_nxt;
  logic                         la_vld_r, la_vld_nxt;
  logic [7:0]                   la_byte_r, la_byte_nxt;
  sst_pkg::pos_t                cur_r, cur_nxt;
  sst_pkg::pos_t                tb_r, tb_nxt;
  logic [sst_pkg::KW_BITS-1:0]  kw_r, kw_nxt;
  logic [3:0]                   idl_r, idl_nxt;
  logic                         flt_r, flt_nxt;

  always_comb begin
    mode_t            m;
    sst_pkg::pos_t    p0, p1, p2, pa;
    logic [7:0]       c0, c1;
    logic             c1_ok, run, num_more;
    logic [1:0]       ncons;
    sst_pkg::rec_t    slot [SLOTS];
    logic [SLOTS-1:0] sv;
    logic [2:0]       k;
    sst_pkg::punct_t  pk;
    sst_pkg::esc_t    es;
    logic [6:0]       nkind;

    c0       = la_byte_r;
    c1       = item_byte;
    c1_ok    = !item_eos;
    run      = item_fire && la_vld_r;
    m        = mode_r;
    tb_nxt   = tb_r;
    kw_nxt   = kw_r;
    idl_nxt  = idl_r;
    flt_nxt  = flt_r;
    ncons    = 2'd0;
    num_more = 1'b0;
    sv       = '0;
    for (int j = 0; j < SLOTS; j++) slot[j] = '0;
    p0 = cur_r;
    p1 = sst_pkg::pos_adv(p0, c0);
    p2 = sst_pkg::pos_adv(p1, c1);
    pk = sst_pkg::punct_find(c0, c1, c1_ok);
    es = sst_pkg::esc_decode(c1);
    nkind = flt_r ? sst_pkg::KIND_FLOAT : sst_pkg::KIND_INT;

    if (run) begin
      // steps that take no byte first: missing exponent sign, end of word or number
      if (m == MODE_EXPSIGN && c0 != "+" && c0 != "-") m = MODE_EXPDIG;
      num_more = sst_pkg::is_digit(c0) || (c0 == "_") ||
                 (m == MODE_INT && c0 == "." && c1_ok && sst_pkg::is_digit(c1)) ||
                 (m != MODE_EXPDIG && (c0 == "e" || c0 == "E")) ||
                 (c0 == "f") || (c0 == "F");
      case (m)
        MODE_LINE: begin
          if (c0 == sst_pkg::CH_LF) m = MODE_IDLE;
        end
        MODE_IDENT: begin
          if (!sst_pkg::is_word(c0)) begin
            slot[0] = sst_pkg::mk_rec(sst_pkg::REC_TOKEN, sst_pkg::ident_kind(kw_r, idl_r),
                                      sst_pkg::ERR_NONE, 8'h00, tb_r, p0);
            sv[0] = 1'b1;
            m = MODE_IDLE;
          end
        end
        MODE_INT, MODE_FRAC, MODE_EXPDIG: begin
          if (!num_more) begin
            slot[0] = sst_pkg::mk_rec(sst_pkg::REC_TOKEN, nkind, sst_pkg::ERR_NONE, 8'h00,
                                      tb_r, p0);
            sv[0] = 1'b1;
            m = MODE_IDLE;
          end
        end
        default: ;
      endcase

      // the step that takes one or two bytes
      case (m)
        MODE_IDLE: begin
          if (sst_pkg::is_space(c0)) begin
            ncons = 2'd1;
          end else if (c0 == "/" && c1_ok && c1 == "/") begin
            ncons = 2'd2;
            m = MODE_LINE;
          end else if (c0 == "/" && c1_ok && c1 == "*") begin
            tb_nxt = p0;
            ncons = 2'd2;
            m = MODE_BLOCK;
          end else begin
            tb_nxt = p0;
            ncons = 2'd1;
            if (sst_pkg::is_alpha(c0) || c0 == "_") begin
              kw_nxt  = {{(sst_pkg::KW_BITS-8){1'b0}}, c0};
              idl_nxt = 4'd1;
              m = MODE_IDENT;
            end else if (sst_pkg::is_digit(c0)) begin
              flt_nxt = 1'b0;
              m = MODE_INT;
            end else if (c0 == "\"") begin
              m = MODE_STR;
            end else if (pk.hit) begin
              if (pk.two) ncons = 2'd2;
              slot[1] = sst_pkg::mk_rec(sst_pkg::REC_TOKEN, pk.kind, sst_pkg::ERR_NONE, 8'h00,
                                        p0, pk.two ? p2 : p1);
              sv[1] = 1'b1;
            end else begin
              slot[1] = sst_pkg::mk_rec(sst_pkg::REC_DIAG, 7'd0, sst_pkg::ERR_UNEXPECTED,
                                        8'h00, p0, p1);
              slot[2] = sst_pkg::mk_rec(sst_pkg::REC_TOKEN, sst_pkg::KIND_INVALID,
                                        sst_pkg::ERR_NONE, 8'h00, p0, p1);
              sv[2:1] = 2'b11;
            end
          end
        end
        MODE_LINE: ncons = 2'd1;
        MODE_BLOCK: begin
          if (c0 == "*" && c1_ok && c1 == "/") begin
            ncons = 2'd2;
            m = MODE_IDLE;
          end else begin
            ncons = 2'd1;
          end
        end
        MODE_IDENT: begin
          ncons = 2'd1;
          if (idl_r < 4'(sst_pkg::KEYWORD_CHARS)) kw_nxt = {kw_r[sst_pkg::KW_BITS-9:0], c0};
          if (idl_r != sst_pkg::IDLEN_MAX) idl_nxt = idl_r + 4'd1;
        end
        MODE_INT, MODE_FRAC, MODE_EXPSIGN, MODE_EXPDIG: begin
          ncons = 2'd1;
          if (m == MODE_EXPSIGN) begin
            m = MODE_EXPDIG;
          end else if (sst_pkg::is_digit(c0) || c0 == "_") begin
            m = m;
          end else if (m == MODE_INT && c0 == ".") begin
            flt_nxt = 1'b1;
            m = MODE_FRAC;
          end else if (m != MODE_EXPDIG && (c0 == "e" || c0 == "E")) begin
            flt_nxt = 1'b1;
            m = MODE_EXPSIGN;
          end else begin
            // float suffix closes the number
            flt_nxt = 1'b1;
            slot[1] = sst_pkg::mk_rec(sst_pkg::REC_TOKEN, sst_pkg::KIND_FLOAT,
                                      sst_pkg::ERR_NONE, 8'h00, tb_r, p1);
            sv[1] = 1'b1;
            m = MODE_IDLE;
          end
        end
        MODE_STR: begin
          ncons = 2'd1;
          if (c0 == "\"") begin
            slot[1] = sst_pkg::mk_rec(sst_pkg::REC_TOKEN, sst_pkg::KIND_STRING,
                                      sst_pkg::ERR_NONE, 8'h00, tb_r, p1);
            sv[1] = 1'b1;
            m = MODE_IDLE;
          end else if (c0 == sst_pkg::CH_LF || c0 == sst_pkg::CH_CR) begin
            slot[1] = sst_pkg::mk_rec(sst_pkg::REC_DIAG, 7'd0, sst_pkg::ERR_NL_IN_STR,
                                      8'h00, tb_r, p1);
            slot[2] = sst_pkg::mk_rec(sst_pkg::REC_DIAG, 7'd0, sst_pkg::ERR_OPEN_STR,
                                      8'h00, tb_r, p1);
            slot[3] = sst_pkg::mk_rec(sst_pkg::REC_TOKEN, sst_pkg::KIND_STRING,
                                      sst_pkg::ERR_NONE, 8'h00, tb_r, p1);
            sv[3:1] = 3'b111;
            m = MODE_IDLE;
          end else if (c0 != "\\") begin
            slot[1] = sst_pkg::mk_rec(sst_pkg::REC_BYTE, 7'd0, sst_pkg::ERR_NONE, c0, p0, p1);
            sv[1] = 1'b1;
          end else if (!c1_ok) begin
            slot[1] = sst_pkg::mk_rec(sst_pkg::REC_DIAG, 7'd0, sst_pkg::ERR_BAD_ESC,
                                      8'h00, p0, p1);
            sv[1] = 1'b1;
          end else begin
            ncons = 2'd2;
            if (es.bad) begin
              slot[1] = sst_pkg::mk_rec(sst_pkg::REC_DIAG, 7'd0, sst_pkg::ERR_BAD_ESC,
                                        8'h00, p1, p2);
              slot[2] = sst_pkg::mk_rec(sst_pkg::REC_BYTE, 7'd0, sst_pkg::ERR_NONE, es.val,
                                        p0, p2);
              sv[2:1] = 2'b11;
            end else begin
              slot[1] = sst_pkg::mk_rec(sst_pkg::REC_BYTE, 7'd0, sst_pkg::ERR_NONE, es.val,
                                        p0, p2);
              sv[1] = 1'b1;
            end
          end
        end
        default: m = MODE_IDLE;
      endcase
    end

    pa = (ncons == 2'd2) ? p2 : ((ncons == 2'd1) ? p1 : p0);

    // end of source: close what is open, then the eof token
    if (item_fire && item_eos) begin
      case (m)
        MODE_BLOCK: begin
          slot[4] = sst_pkg::mk_rec(sst_pkg::REC_DIAG, 7'd0, sst_pkg::ERR_OPEN_CMT, 8'h00,
                                    tb_nxt, pa);
          sv[4] = 1'b1;
        end
        MODE_IDENT: begin
          slot[4] = sst_pkg::mk_rec(sst_pkg::REC_TOKEN, sst_pkg::ident_kind(kw_nxt, idl_nxt),
                                    sst_pkg::ERR_NONE, 8'h00, tb_nxt, pa);
          sv[4] = 1'b1;
        end
        MODE_INT, MODE_FRAC, MODE_EXPSIGN, MODE_EXPDIG: begin
          slot[4] = sst_pkg::mk_rec(sst_pkg::REC_TOKEN,
                                    flt_nxt ? sst_pkg::KIND_FLOAT : sst_pkg::KIND_INT,
                                    sst_pkg::ERR_NONE, 8'h00, tb_nxt, pa);
          sv[4] = 1'b1;
        end
        MODE_STR: begin
          slot[4] = sst_pkg::mk_rec(sst_pkg::REC_DIAG, 7'd0, sst_pkg::ERR_OPEN_STR, 8'h00,
                                    tb_nxt, pa);
          slot[5] = sst_pkg::mk_rec(sst_pkg::REC_TOKEN, sst_pkg::KIND_STRING,
                                    sst_pkg::ERR_NONE, 8'h00, tb_nxt, pa);
          sv[5:4] = 2'b11;
        end
        default: ;
      endcase
      slot[6] = sst_pkg::mk_rec(sst_pkg::REC_TOKEN, sst_pkg::KIND_EOF, sst_pkg::ERR_NONE,
                                8'h00, pa, pa);
      sv[6] = 1'b1;
    end

    // pack the live slots in order, keeping at most one batch
    batch = '0;
    k = 3'd0;
    for (int j = 0; j < SLOTS; j++) begin
      if (sv[j]) begin
        if (k < 3'(sst_pkg::BATCH_RECS)) batch.recs[k[sst_pkg::REC_IDX_BITS-1:0]] = slot[j];
        k = k + 3'd1;
      end
    end
    batch.cnt  = (k > 3'(sst_pkg::BATCH_RECS)) ? sst_pkg::BATCH_CNT_BITS'(sst_pkg::BATCH_RECS)
                                               : sst_pkg::BATCH_CNT_BITS'(k);
    batch_push = item_fire && (k != 3'd0);

    mode_nxt    = m;
    cur_nxt     = pa;
    la_vld_nxt  = la_vld_r;
    la_byte_nxt = la_byte_r;
    if (item_fire) begin
      if (item_eos) begin
        mode_nxt    = MODE_IDLE;
        la_vld_nxt  = 1'b0;
        la_byte_nxt = 8'h00;
        cur_nxt     = sst_pkg::POS_START;
        tb_nxt      = '0;
        kw_nxt      = '0;
        idl_nxt     = 4'd0;
        flt_nxt     = 1'b0;
      end else if (!la_vld_r || ncons == 2'd1) begin
        la_vld_nxt  = 1'b1;
        la_byte_nxt = item_byte;
      end else begin
        la_vld_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      la_vld_r  <= 1'b0;
      la_byte_r <= 8'h00;
      cur_r     <= sst_pkg::POS_START;
      tb_r      <= '0;
      kw_r      <= '0;
      idl_r     <= 4'd0;
      flt_r     <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      la_vld_r  <= la_vld_nxt;
      la_byte_r <= la_byte_nxt;
      cur_r     <= cur_nxt;
      tb_r      <= tb_nxt;
      kw_r      <= kw_nxt;
      idl_r     <= idl_nxt;
      flt_r     <= flt_nxt;
    end
  end

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    item_fire && item_eos |=> !la_vld_r && mode_r == MODE_IDLE &&
                              cur_r == sst_pkg::POS_START)
    else $error("scanner not back at start after end of source");

  a_first_byte_held: assert property (@(posedge clk) disable iff (!rst_n)
    item_fire && !item_eos && !la_vld_r |=> la_vld_r && $stable(cur_r) && $stable(mode_r))
    else $error("byte into empty lookahead changed the scan");

endmodule

// File: rtl/sst_queue.sv
`timescale 1ns / 1ps
// queue of record batches, drained one record per item on the output side
module sst_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sst_pkg::batch_t push_batch,
  output logic            full,
  output logic            out_valid,
  input  logic            out_ready,
  output sst_pkg::rec_t   out_rec,
  output logic            out_last
);

  sst_pkg::batch_t                    mem_r [sst_pkg::QUEUE_DEPTH];
  logic [sst_pkg::QPTR_BITS-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [sst_pkg::QPTR_BITS-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [sst_pkg::QPTR_BITS:0]        cnt_r, cnt_nxt;
  logic [sst_pkg::REC_IDX_BITS-1:0]   idx_r, idx_nxt;
  sst_pkg::batch_t                    head;
  logic                               pop_rec, pop_batch;

  assign head      = mem_r[rd_ptr_r];
  assign full      = (cnt_r == (sst_pkg::QPTR_BITS+1)'(sst_pkg::QUEUE_DEPTH));
  assign out_valid = (cnt_r != '0);
  assign out_rec   = head.recs[idx_r];
  assign out_last  = (sst_pkg::BATCH_CNT_BITS'(idx_r) + 1'b1) == head.cnt;
  assign pop_rec   = out_valid && out_ready;
  assign pop_batch = pop_rec && out_last;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_batch ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (sst_pkg::QPTR_BITS+1)'(push) - (sst_pkg::QPTR_BITS+1)'(pop_batch);
    idx_nxt    = pop_batch ? '0 : (pop_rec ? idx_r + 1'b1 : idx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      idx_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_batch;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full && push_batch.cnt != '0)
    else $error("batch pushed into a full queue or with no records");

  a_idx_in_batch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> sst_pkg::BATCH_CNT_BITS'(idx_r) < head.cnt)
    else $error("record index beyond its batch");

endmodule

// File: rtl/script_source_tokenizer.sv
`timescale 1ns / 1ps
// top level of the source tokenizer: input register, scanner and record queue
//
//  channel | dir | handshake         | payload
//  in_     | in  | in_tvalid/tready  | tdata source byte, tlast end of source
//  out_    | out | out_tvalid/tready | tdata token record, tuser record type,
//          |     |                   | tlast final record of its item
//
// one item is taken every cycle while the queue is not full; it is held in the input
// register until the queue has room, then the scanner pushes its records into the batch
// queue, from which the first record is offered. records leave one per cycle while
// out_tready is high; input stalls only while the four-batch queue is full.
// synchronous active-low reset empties the lookahead and puts the position back at
// offset 0, line 1, column 1.
module script_source_tokenizer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,  // source_byte
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // token_kind, error_code, string_byte, begin_offset, begin_line,
  // begin_column, end_offset, end_line, end_column, zero pad
  output logic [sst_pkg::OUT_TDATA_BITS-1:0] out_tdata,
  output logic [1:0]                         out_tuser, // record_type
  output logic                               out_tlast
);

  logic            in_vld_r, in_vld_nxt;
  logic [7:0]      in_byte_r;
  logic            in_eos_r;
  logic            in_fire, proc;
  logic            q_full;
  sst_pkg::batch_t batch;
  logic            batch_push;
  sst_pkg::rec_t   rec;

  assign proc      = in_vld_r && !q_full;
  assign in_tready = !in_vld_r || proc;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    in_vld_nxt = in_fire ? 1'b1 : (proc ? 1'b0 : in_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_tdata;
      in_eos_r  <= in_tlast;
    end
  end

  sst_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_fire  (proc),
    .item_byte  (in_byte_r),
    .item_eos   (in_eos_r),
    .batch      (batch),
    .batch_push (batch_push)
  );

  sst_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (batch_push),
    .push_batch (batch),
    .full       (q_full),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_rec    (rec),
    .out_last   (out_tlast)
  );

  assign out_tdata = {6'b0, rec.epos.col, rec.epos.line, rec.epos.off,
                      rec.bpos.col, rec.bpos.line, rec.bpos.off,
                      rec.sbyte, rec.err, rec.kind};
  assign out_tuser = rec.rtype;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && q_full |=> in_vld_r && $stable(in_byte_r) && $stable(in_eos_r))
    else $error("held item lost while the queue was full");

endmodule

// File: tb/tb_script_source_tokenizer.sv
`timescale 1ns / 1ps
// self-checking testbench of the source tokenizer with a scoreboard class
module tb_script_source_tokenizer;

  localparam int NO_BYTE     = 256;
  localparam int WATCH_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 12;

  typedef enum logic [3:0] {
    SC_IDLE, SC_LINE, SC_BLOCK, SC_IDENT, SC_INT, SC_FRAC, SC_EXPSIGN, SC_EXPDIG, SC_STR
  } scan_t;

  typedef struct {
    sst_pkg::rec_t rec;
    logic          last;
  } token_rec_t;

  class tokenizer_scoreboard;
    token_rec_t    expected_recs[$];
    token_rec_t    batch[$];
    int            errors;
    scan_t         mode;
    logic [7:0]    look[2];
    int            look_n;
    sst_pkg::pos_t cur, tbeg;
    logic [63:0]   word;
    logic [3:0]    word_len;
    logic          is_float;
    string         keywords[30] = '{
      "true", "false", "null", "module", "use", "script", "fn", "return",
      "if", "else", "while", "for", "in", "let", "var", "const", "struct",
      "enum", "class", "signal", "on", "async", "await", "emit", "match",
      "break", "continue", "public", "private", "static"};

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      mode = SC_IDLE;
      look[0] = 0;
      look[1] = 0;
      look_n = 0;
      cur = sst_pkg::POS_START;
      tbeg = '0;
      word = '0;
      word_len = 0;
      is_float = 0;
    endfunction

    function void add(logic [1:0] rt, logic [6:0] k, logic [2:0] e, logic [7:0] sb,
                      sst_pkg::pos_t b, sst_pkg::pos_t p);
      token_rec_t t;
      if (batch.size() >= 4) return;
      t.rec = '{rtype: rt, kind: k, err: e, sbyte: sb, bpos: b, epos: p};
      t.last = 0;
      batch.insert(batch.size(), t);
    endfunction

    function void token(logic [6:0] k);
      add(sst_pkg::REC_TOKEN, k, sst_pkg::ERR_NONE, 0, tbeg, cur);
      mode = SC_IDLE;
    endfunction

    function void consume();
      if (look_n == 0) return;
      if (cur.off != '1) cur.off++;
      if (look[0] == sst_pkg::CH_LF) begin
        if (cur.line != '1) cur.line++;
        cur.col = 1;
      end else if (cur.col != '1) begin
        cur.col++;
      end
      look[0] = look[1];
      look[1] = 0;
      look_n--;
    endfunction

    function logic [6:0] word_kind();
      logic [63:0] v;
      if (word_len > 8) return sst_pkg::KIND_IDENT;
      for (int k = 0; k < 30; k++) begin
        v = '0;
        for (int i = 0; i < keywords[k].len(); i++) v[8*i +: 8] = keywords[k][i];
        if (v == word) return 7'(k);
      end
      return sst_pkg::KIND_IDENT;
    endfunction

    function int punct(int c0, int c1, output bit two);
      two = 0;
      case (c0)
        "{": return sst_pkg::KIND_LBRACE;
        "}": return sst_pkg::KIND_RBRACE;
        "(": return sst_pkg::KIND_LPAREN;
        ")": return sst_pkg::KIND_RPAREN;
        "[": return sst_pkg::KIND_LBRACK;
        "]": return sst_pkg::KIND_RBRACK;
        ",": return sst_pkg::KIND_COMMA;
        ".": return sst_pkg::KIND_DOT;
        ";": return sst_pkg::KIND_SEMI;
        "@": return sst_pkg::KIND_AT;
        "?": return sst_pkg::KIND_QUEST;
        "+": return sst_pkg::KIND_PLUS;
        "*": return sst_pkg::KIND_STAR;
        "/": return sst_pkg::KIND_SLASH;
        "%": return sst_pkg::KIND_PERCENT;
        ":": begin
          two = (c1 == ":");
          return two ? sst_pkg::KIND_DCOLON : sst_pkg::KIND_COLON;
        end
        "-": begin
          two = (c1 == ">");
          return two ? sst_pkg::KIND_ARROW : sst_pkg::KIND_MINUS;
        end
        "=": begin
          two = (c1 == "=");
          return two ? sst_pkg::KIND_EQEQ : sst_pkg::KIND_ASSIGN;
        end
        "!": begin
          two = (c1 == "=");
          return two ? sst_pkg::KIND_NE : sst_pkg::KIND_BANG;
        end
        "<": begin
          two = (c1 == "=");
          return two ? sst_pkg::KIND_LE : sst_pkg::KIND_LT;
        end
        ">": begin
          two = (c1 == "=");
          return two ? sst_pkg::KIND_GE : sst_pkg::KIND_GT;
        end
        "&": begin
          two = (c1 == "&");
          return two ? sst_pkg::KIND_ANDAND : sst_pkg::KIND_AMP;
        end
        "|": begin
          two = (c1 == "|");
          return two ? sst_pkg::KIND_OROR : sst_pkg::KIND_PIPE;
        end
        default: return -1;
      endcase
    endfunction

    function bit digit(int c);
      return c >= "0" && c <= "9";
    endfunction

    function bit alpha(int c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function void idle_step(int c0, int c1);
      bit two;
      int k;
      if (c0 == " " || c0 == sst_pkg::CH_TAB || c0 == sst_pkg::CH_VT ||
          c0 == sst_pkg::CH_FF || c0 == sst_pkg::CH_CR || c0 == sst_pkg::CH_LF) begin
        consume();
        return;
      end
      if (c0 == "/" && (c1 == "/" || c1 == "*")) begin
        if (c1 == "*") tbeg = cur;
        consume();
        consume();
        mode = (c1 == "/") ? SC_LINE : SC_BLOCK;
        return;
      end
      tbeg = cur;
      consume();
      if (c0 == "_" || alpha(c0)) begin
        word = 64'(c0);
        word_len = 1;
        mode = SC_IDENT;
      end else if (digit(c0)) begin
        is_float = 0;
        mode = SC_INT;
      end else if (c0 == "\"") begin
        mode = SC_STR;
      end else begin
        k = punct(c0, c1, two);
        if (k < 0) begin
          add(sst_pkg::REC_DIAG, 0, sst_pkg::ERR_UNEXPECTED, 0, tbeg, cur);
          token(sst_pkg::KIND_INVALID);
        end else begin
          if (two) consume();
          token(7'(k));
        end
      end
    endfunction

    function void string_step(int c0, int c1);
      sst_pkg::pos_t p, q;
      logic [7:0] d;
      p = cur;
      consume();
      if (c0 == "\"") begin
        token(sst_pkg::KIND_STRING);
      end else if (c0 == sst_pkg::CH_LF || c0 == sst_pkg::CH_CR) begin
        add(sst_pkg::REC_DIAG, 0, sst_pkg::ERR_NL_IN_STR, 0, tbeg, cur);
        add(sst_pkg::REC_DIAG, 0, sst_pkg::ERR_OPEN_STR, 0, tbeg, cur);
        token(sst_pkg::KIND_STRING);
      end else if (c0 != "\\") begin
        add(sst_pkg::REC_BYTE, 0, sst_pkg::ERR_NONE, 8'(c0), p, cur);
      end else if (c1 == NO_BYTE) begin
        add(sst_pkg::REC_DIAG, 0, sst_pkg::ERR_BAD_ESC, 0, p, cur);
      end else begin
        q = cur;
        consume();
        case (c1)
          "n": d = sst_pkg::CH_LF;
          "r": d = sst_pkg::CH_CR;
          "t": d = sst_pkg::CH_TAB;
          "0": d = 8'h00;
          "\\": d = "\\";
          "\"": d = "\"";
          default: begin
            add(sst_pkg::REC_DIAG, 0, sst_pkg::ERR_BAD_ESC, 0, q, cur);
            d = 8'(c1);
          end
        endcase
        add(sst_pkg::REC_BYTE, 0, sst_pkg::ERR_NONE, d, p, cur);
      end
    endfunction

    function void number_step(int c0, int c1);
      if (mode == SC_EXPSIGN) begin
        if (c0 == "+" || c0 == "-") consume();
        mode = SC_EXPDIG;
      end else if (digit(c0) || c0 == "_") begin
        consume();
      end else if (mode == SC_INT && c0 == "." && digit(c1)) begin
        is_float = 1;
        consume();
        mode = SC_FRAC;
      end else if (mode != SC_EXPDIG && (c0 == "e" || c0 == "E")) begin
        is_float = 1;
        consume();
        mode = SC_EXPSIGN;
      end else begin
        if (c0 == "f" || c0 == "F") begin
          is_float = 1;
          consume();
        end
        token(is_float ? sst_pkg::KIND_FLOAT : sst_pkg::KIND_INT);
      end
    endfunction

    function void scan_one();
      int c0, c1;
      c0 = look[0];
      c1 = (look_n >= 2) ? int'(look[1]) : NO_BYTE;
      case (mode)
        SC_IDLE: idle_step(c0, c1);
        SC_LINE: if (c0 == sst_pkg::CH_LF) mode = SC_IDLE; else consume();
        SC_BLOCK: begin
          if (c0 == "*" && c1 == "/") begin
            consume();
            consume();
            mode = SC_IDLE;
          end else begin
            consume();
          end
        end
        SC_IDENT: begin
          if (c0 == "_" || alpha(c0) || digit(c0)) begin
            if (word_len < 8) word[8*word_len +: 8] = 8'(c0);
            if (word_len < 15) word_len++;
            consume();
          end else begin
            token(word_kind());
          end
        end
        SC_INT, SC_FRAC, SC_EXPSIGN, SC_EXPDIG: number_step(c0, c1);
        SC_STR: string_step(c0, c1);
        default: mode = SC_IDLE;
      endcase
    endfunction

    // works out the records one accepted item causes
    function void note_item(logic [7:0] b, logic eos);
      batch.delete();
      if (!eos) begin
        if (look_n < 2) begin
          look[look_n] = b;
          look_n++;
        end
        while (look_n == 2) scan_one();
      end else begin
        while (look_n >= 1) scan_one();
        case (mode)
          SC_BLOCK: add(sst_pkg::REC_DIAG, 0, sst_pkg::ERR_OPEN_CMT, 0, tbeg, cur);
          SC_IDENT: token(word_kind());
          SC_INT, SC_FRAC, SC_EXPSIGN, SC_EXPDIG:
            token(is_float ? sst_pkg::KIND_FLOAT : sst_pkg::KIND_INT);
          SC_STR: begin
            add(sst_pkg::REC_DIAG, 0, sst_pkg::ERR_OPEN_STR, 0, tbeg, cur);
            token(sst_pkg::KIND_STRING);
          end
          default: ;
        endcase
        add(sst_pkg::REC_TOKEN, sst_pkg::KIND_EOF, sst_pkg::ERR_NONE, 0, cur, cur);
        clear();
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1;
      foreach (batch[i]) expected_recs.insert(expected_recs.size(), batch[i]);
    endfunction

    function void check(sst_pkg::rec_t got, logic got_last);
      token_rec_t want;
      if (expected_recs.size() == 0) begin
        $display("%0t: unexpected record %h last %b", $time, got, got_last);
        errors++;
        return;
      end
      want = expected_recs.pop_front();
      if (got.rtype !== want.rec.rtype || got.kind !== want.rec.kind ||
          got.err !== want.rec.err || got.sbyte !== want.rec.sbyte ||
          got.bpos !== want.rec.bpos || got.epos !== want.rec.epos ||
          got_last !== want.last) begin
        $display("%0t: mismatch expected %h last %b, actual %h last %b",
                 $time, want.rec, want.last, got, got_last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0, in_tlast = 0, out_tready = 0;
  logic [7:0] in_tdata = 0;
  logic in_tready, out_tvalid, out_tlast;
  logic [sst_pkg::OUT_TDATA_BITS-1:0] out_tdata;
  logic [1:0] out_tuser;

  tokenizer_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold = 0;
  int quiet_cycles = 0;
  int random_items = 0;

  script_source_tokenizer i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver: random stalls plus the long hold-off
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_tready <= 0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    sst_pkg::rec_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.rtype = out_tuser;
      got.kind  = out_tdata[6:0];
      got.err   = out_tdata[9:7];
      got.sbyte = out_tdata[17:10];
      got.bpos  = '{off: out_tdata[41:18], line: out_tdata[61:42], col: out_tdata[77:62]};
      got.epos  = '{off: out_tdata[101:78], line: out_tdata[121:102],
                    col: out_tdata[137:122]};
      sb.check(got, out_tlast);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("script_source_tokenizer verification failed");
      $finish;
    end
  end

  task automatic send_item(logic [7:0] b, logic eos);
    while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk);
    in_tvalid = 1;
    in_tdata  = b;
    in_tlast  = eos;
    do @(posedge clk); while (!in_tready);
    sb.note_item(b, eos);
    @(negedge clk);
    in_tvalid = 0;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 0);
  endtask

  task automatic end_source();
    send_item(8'($urandom), 1);
  endtask

  task automatic wait_drained();
    while (sb.expected_recs.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // fragments, some of them malformed, in random order, plus some noise
  task automatic random_source(int n);
    string frags[] = '{"true", "false", "null", "module", "use", "script", "fn",
      "return", "if", "else", "while", "for", "in", "let", "var", "const", "struct",
      "enum", "class", "signal", "on", "async", "await", "emit", "match", "break",
      "continue", "public", "private", "static", "continues", "_q9", "Ab_z", "x",
      "{", "}", "(", ")", "[", "]", ",", ".", "::", ":", ";", "@", "?", "+", "->", "-",
      "*", "/", "%", "==", "=", "!=", "!", "<=", "<", ">=", ">", "&&", "&", "||", "|",
      "42", "1_000", "3.25", "7e-3", "6E+2f", "9f", "1.x", "2ee", "\"hi\"",
      "\"a\\n\\t\\r\\0\\\\\\\"b\"", "\"\\z\"", "// note\n", "/* c * / */", "\t", "\n",
      " ", "\r\n", "\"open\n"};
    int goal;
    int sel;
    goal = random_items + n;
    while (random_items < goal) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        send_item(8'($urandom), 0);
        random_items++;
      end else if (sel == 1) begin
        end_source();
        random_items++;
      end else begin
        string f;
        f = frags[$urandom_range(0, frags.size() - 1)];
        send_text(f);
        random_items += f.len();
        if ($urandom_range(0, 2) != 0) begin
          send_item(" ", 0);
          random_items++;
        end
      end
    end
    end_source();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1;

    // directed: escapes, extreme bytes, open comment, trailing backslash,
    // newline inside a string and an open string
    send_text("\"a\\q\\n\" ");
    send_item(8'h00, 0);
    send_item(8'hFF, 0);
    send_text("x /*");
    end_source();
    send_text("\"s\\");
    end_source();
    send_text("\"b\n\"e");
    end_source();
    wait_drained();

    send_idle_pct = 25;
    recv_idle_pct = 56;
    random_source(25);
    // long hold-off so the queue fills and input stalls
    recv_hold = 150;
    send_text("(){}[],;");
    random_source(8);
    wait_drained();

    send_idle_pct = 56;
    recv_idle_pct = 25;
    random_source(25);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_source(25);
    wait_drained();

    if (sb.errors == 0 && sb.expected_recs.size() == 0) begin
      $display("script_source_tokenizer verification clean");
    end else begin
      $display("script_source_tokenizer verification failed");
    end
    $finish;
  end

endmodule
